// ===== src/dpd_pkg.sv =====
package dpd_pkg;

    // Field and datapath widths
    localparam int POS_W   = 24;
    localparam int SUM_W   = 32;
    localparam int GF_W    = 16;
    localparam int GAIN_W  = 20;
    localparam int ZONE_W  = 16;
    localparam int SPEED_W = 11;

    localparam int CFG_W     = GAIN_W;
    localparam int CFG_IDX_W = 3;

    localparam int ERR_W   = POS_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int ACC_W   = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
    localparam int PPROD_W = ERR_W + GAIN_W + 1;
    localparam int DPROD_W = DIFF_W + GAIN_W + 1;
    localparam int IPROD_W = SUM_W + GAIN_W;
    localparam int PD_MAX_W = (PPROD_W > DPROD_W) ? PPROD_W : DPROD_W;
    localparam int POW_W   = ((PD_MAX_W > IPROD_W + 1) ? PD_MAX_W : IPROD_W + 1) + 2;
    localparam int ZCMP_W  = ZONE_W + ERR_W;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_P_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_P_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_I_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_I_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_D_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_D_GAIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_ZONE      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ZONE     = 3'd7;

    // Reset values
    localparam logic [GAIN_W-1:0] P_GAIN_RST = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0] I_GAIN_RST = '0;
    localparam logic [GAIN_W-1:0] D_GAIN_RST = '0;
    localparam logic [ZONE_W-1:0] ZONE_RST   = ZONE_W'(10);

    typedef struct packed {
        logic [GAIN_W-1:0] p_gain;
        logic [GAIN_W-1:0] i_gain;
        logic [GAIN_W-1:0] d_gain;
        logic [ZONE_W-1:0] zone;
    } t_side_cfg;

    // Stage loads and controls of the shared pipeline
    typedef struct packed {
        logic ld_a;
        logic ld_b;
        logic ld_c;
        logic ld_d;
        logic ld_e;
        logic run_b;
        logic done_d;
    } t_pipe_ctl;

endpackage

// ===== src/dpd_cfg.sv =====
module dpd_cfg import dpd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output t_side_cfg            o_left_cfg,
    output t_side_cfg            o_right_cfg
);

    t_side_cfg r_left;
    t_side_cfg r_right;
    t_side_cfg n_left;
    t_side_cfg n_right;

    always_comb begin
        n_left  = r_left;
        n_right = r_right;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_LEFT_P_GAIN:  n_left.p_gain  = i_cfg_wdata[GAIN_W-1:0];
                REG_RIGHT_P_GAIN: n_right.p_gain = i_cfg_wdata[GAIN_W-1:0];
                REG_LEFT_I_GAIN:  n_left.i_gain  = i_cfg_wdata[GAIN_W-1:0];
                REG_RIGHT_I_GAIN: n_right.i_gain = i_cfg_wdata[GAIN_W-1:0];
                REG_LEFT_D_GAIN:  n_left.d_gain  = i_cfg_wdata[GAIN_W-1:0];
                REG_RIGHT_D_GAIN: n_right.d_gain = i_cfg_wdata[GAIN_W-1:0];
                REG_LEFT_ZONE:    n_left.zone    = i_cfg_wdata[ZONE_W-1:0];
                REG_RIGHT_ZONE:   n_right.zone   = i_cfg_wdata[ZONE_W-1:0];
                default: begin
                    n_left  = r_left;
                    n_right = r_right;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '{p_gain: P_GAIN_RST, i_gain: I_GAIN_RST, d_gain: D_GAIN_RST,
                         zone: ZONE_RST};
            r_right <= '{p_gain: P_GAIN_RST, i_gain: I_GAIN_RST, d_gain: D_GAIN_RST,
                         zone: ZONE_RST};
        end else begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_left_cfg  = r_left;
    assign o_right_cfg = r_right;

endmodule

// ===== src/dpd_side.sv =====
module dpd_side import dpd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_pipe_ctl                 i_ctl,
    input  t_side_cfg                 i_cfg,
    input  logic signed [POS_W-1:0]   i_position,
    input  logic signed [POS_W-1:0]   i_goal,
    input  logic signed [SPEED_W-1:0] i_top_speed,
    input  logic signed [SPEED_W-1:0] i_low_speed,
    output logic                      o_short,
    output logic signed [SPEED_W-1:0] o_power
);

    // Stage A: input register
    logic signed [POS_W-1:0]   r_pos_a;
    logic signed [POS_W-1:0]   r_goal_a;
    logic signed [SPEED_W-1:0] r_top_a;
    logic signed [SPEED_W-1:0] r_low_a;

    // Loop state
    logic signed [SUM_W-1:0] r_sum;
    logic signed [ERR_W-1:0] r_last;

    // Stage B
    logic signed [ERR_W-1:0]   r_err_b;
    logic signed [SUM_W-1:0]   r_sum_b;
    logic signed [DIFF_W-1:0]  r_diff_b;
    logic signed [SPEED_W-1:0] r_top_b;
    logic signed [SPEED_W-1:0] r_low_b;

    // Stage C
    logic signed [PPROD_W-1:0] r_pprod_c;
    logic signed [DPROD_W-1:0] r_dprod_c;
    logic [IPROD_W-1:0]        r_iprod_c;
    logic                      r_sneg_c;
    logic                      r_inzone_c;
    logic signed [SPEED_W-1:0] r_top_c;
    logic signed [SPEED_W-1:0] r_low_c;

    // Stage D
    logic signed [POW_W-1:0]   r_power_d;
    logic signed [SPEED_W-1:0] r_top_d;
    logic signed [SPEED_W-1:0] r_low_d;

    // Stage E
    logic signed [SPEED_W-1:0] r_power_e;

    // Done test on the input register
    logic [POS_W-1:0] pos_mag;
    logic [POS_W-1:0] goal_mag;

    assign pos_mag  = r_pos_a[POS_W-1]  ? POS_W'(-r_pos_a)  : POS_W'(r_pos_a);
    assign goal_mag = r_goal_a[POS_W-1] ? POS_W'(-r_goal_a) : POS_W'(r_goal_a);
    assign o_short  = ({1'b0, pos_mag} + (POS_W+1)'(1)) < {1'b0, goal_mag};

    // Stage B logic: error, saturating sum, difference
    logic signed [ERR_W-1:0]  err;
    logic signed [ACC_W-1:0]  acc;
    logic signed [SUM_W-1:0]  sum_sat;
    logic signed [DIFF_W-1:0] diff;

    assign err  = ERR_W'(r_goal_a) - ERR_W'(r_pos_a);
    assign acc  = ACC_W'(r_sum) + ACC_W'(err);
    assign diff = DIFF_W'(err) - DIFF_W'(r_last);

    always_comb begin
        if (acc > ACC_W'(SUM_MAX)) begin
            sum_sat = SUM_MAX;
        end else if (acc < ACC_W'(SUM_MIN)) begin
            sum_sat = SUM_MIN;
        end else begin
            sum_sat = acc[SUM_W-1:0];
        end
    end

    // Stage C logic: three products and the zone test
    logic [ERR_W-1:0]          err_mag;
    logic [SUM_W-1:0]          sum_mag;
    logic                      inzone;
    logic signed [PPROD_W-1:0] pprod;
    logic signed [DPROD_W-1:0] dprod;
    logic [IPROD_W-1:0]        iprod;

    assign err_mag = r_err_b[ERR_W-1] ? ERR_W'(-r_err_b) : ERR_W'(r_err_b);
    assign sum_mag = r_sum_b[SUM_W-1] ? SUM_W'(-r_sum_b) : SUM_W'(r_sum_b);
    assign inzone  = ZCMP_W'(err_mag) <= ZCMP_W'(i_cfg.zone);
    assign pprod   = PPROD_W'(r_err_b) * PPROD_W'($signed({1'b0, i_cfg.p_gain}));
    assign dprod   = DPROD_W'(r_diff_b) * DPROD_W'($signed({1'b0, i_cfg.d_gain}));
    assign iprod   = IPROD_W'(sum_mag) * IPROD_W'(i_cfg.i_gain);

    // Stage D logic: integer-truncated integral term and the sum of terms
    logic [IPROD_W-1:0]      iprod_int;
    logic signed [POW_W-1:0] iterm;
    logic signed [POW_W-1:0] power;

    assign iprod_int = {r_iprod_c[IPROD_W-1:GF_W], {GF_W{1'b0}}};

    always_comb begin
        if (!r_inzone_c) begin
            iterm = '0;
        end else if (r_sneg_c) begin
            iterm = -$signed(POW_W'(iprod_int));
        end else begin
            iterm = $signed(POW_W'(iprod_int));
        end
    end

    assign power = POW_W'(r_pprod_c) + POW_W'(r_dprod_c) + iterm;

    // Stage E logic: speed limits and output saturation
    logic [POW_W-1:0]   pow_mag;
    logic [SPEED_W-1:0] top_mag;
    logic [SPEED_W-1:0] low_mag;
    logic [SPEED_W-1:0] whole;
    logic               gt_top;
    logic               lt_low;
    logic signed [SPEED_W-1:0] limited;

    assign pow_mag = r_power_d[POW_W-1] ? POW_W'(-r_power_d) : POW_W'(r_power_d);
    assign top_mag = r_top_d[SPEED_W-1] ? SPEED_W'(-r_top_d) : SPEED_W'(r_top_d);
    assign low_mag = r_low_d[SPEED_W-1] ? SPEED_W'(-r_low_d) : SPEED_W'(r_low_d);
    assign gt_top  = pow_mag > POW_W'({top_mag, {GF_W{1'b0}}});
    // Used only where the magnitude does not exceed the top limit, so the integer part fits
    assign whole   = pow_mag[GF_W +: SPEED_W];

    always_comb begin
        if (gt_top) begin
            lt_low = top_mag < low_mag;
        end else begin
            lt_low = pow_mag < POW_W'({low_mag, {GF_W{1'b0}}});
        end

        if (lt_low) begin
            limited = r_low_d;
        end else if (gt_top) begin
            limited = r_top_d;
        end else if (r_power_d[POW_W-1]) begin
            limited = -$signed(whole);
        end else if (whole[SPEED_W-1]) begin
            limited = SPEED_MAX;
        end else begin
            limited = $signed(whole);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_last <= '0;
        end else if (i_ctl.ld_b && i_ctl.run_b) begin
            r_sum  <= sum_sat;
            r_last <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_a) begin
            r_pos_a  <= i_position;
            r_goal_a <= i_goal;
            r_top_a  <= i_top_speed;
            r_low_a  <= i_low_speed;
        end
        if (i_ctl.ld_b) begin
            r_err_b  <= err;
            r_sum_b  <= sum_sat;
            r_diff_b <= diff;
            r_top_b  <= r_top_a;
            r_low_b  <= r_low_a;
        end
        if (i_ctl.ld_c) begin
            r_pprod_c  <= pprod;
            r_dprod_c  <= dprod;
            r_iprod_c  <= iprod;
            r_sneg_c   <= r_sum_b[SUM_W-1];
            r_inzone_c <= inzone;
            r_top_c    <= r_top_b;
            r_low_c    <= r_low_b;
        end
        if (i_ctl.ld_d) begin
            r_power_d <= power;
            r_top_d   <= r_top_c;
            r_low_d   <= r_low_c;
        end
        if (i_ctl.ld_e) begin
            r_power_e <= i_ctl.done_d ? '0 : limited;
        end
    end

    assign o_power = r_power_e;

    a_state_hold_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.ld_b && !i_ctl.run_b |=> $stable(r_sum) && $stable(r_last))
        else $error("loop state changed on a finished move");

    a_state_tracks_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.ld_b && i_ctl.run_b |=> r_last == r_err_b && r_sum == r_sum_b)
        else $error("loop state disagrees with the staged error");

endmodule

// ===== src/dual_pid_drive_step.sv =====
// Five register stages (input, error/sum, multiply, term sum, limit/output
// register) lie between an input transfer and o_out_valid.
// Throughput: one item per cycle while i_out_ready is high; each stage moves on
// when its successor is empty or moving, so a full pipeline keeps that rate.
// Reset (i_rst_n low, synchronous): pipeline emptied, error sums and last
// errors cleared, gains and zones back to their default values.
module dual_pid_drive_step import dpd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [POS_W-1:0]   i_left_position,
    input  logic signed [POS_W-1:0]   i_right_position,
    input  logic signed [POS_W-1:0]   i_left_goal,
    input  logic signed [POS_W-1:0]   i_right_goal,
    input  logic signed [SPEED_W-1:0] i_left_top_speed,
    input  logic signed [SPEED_W-1:0] i_right_top_speed,
    input  logic signed [SPEED_W-1:0] i_left_low_speed,
    input  logic signed [SPEED_W-1:0] i_right_low_speed,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [SPEED_W-1:0] o_left_power,
    output logic signed [SPEED_W-1:0] o_right_power,
    output logic                      o_move_done
);

    t_side_cfg left_cfg;
    t_side_cfg right_cfg;
    t_pipe_ctl ctl;

    logic r_vld_a, r_vld_b, r_vld_c, r_vld_d, r_vld_e;
    logic r_done_b, r_done_c, r_done_d, r_done_e;
    logic rdy_b, rdy_c, rdy_d, rdy_e;
    logic left_short, right_short;

    // A stage may take a new item when empty or when its item moves on
    assign rdy_e = !r_vld_e || i_out_ready;
    assign rdy_d = !r_vld_d || rdy_e;
    assign rdy_c = !r_vld_c || rdy_d;
    assign rdy_b = !r_vld_b || rdy_c;
    assign o_in_ready = !r_vld_a || rdy_b;

    assign ctl.ld_a   = i_in_valid && o_in_ready;
    assign ctl.ld_b   = r_vld_a && rdy_b;
    assign ctl.ld_c   = r_vld_b && rdy_c;
    assign ctl.ld_d   = r_vld_c && rdy_d;
    assign ctl.ld_e   = r_vld_d && rdy_e;
    assign ctl.run_b  = left_short || right_short;
    assign ctl.done_d = r_done_d;

    dpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_left_cfg  (left_cfg),
        .o_right_cfg (right_cfg)
    );

    dpd_side u_left (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_cfg       (left_cfg),
        .i_position  (i_left_position),
        .i_goal      (i_left_goal),
        .i_top_speed (i_left_top_speed),
        .i_low_speed (i_left_low_speed),
        .o_short     (left_short),
        .o_power     (o_left_power)
    );

    dpd_side u_right (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_cfg       (right_cfg),
        .i_position  (i_right_position),
        .i_goal      (i_right_goal),
        .i_top_speed (i_right_top_speed),
        .i_low_speed (i_right_low_speed),
        .o_short     (right_short),
        .o_power     (o_right_power)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
        end else begin
            r_vld_a <= ctl.ld_a || (r_vld_a && !ctl.ld_b);
            r_vld_b <= ctl.ld_b || (r_vld_b && !ctl.ld_c);
            r_vld_c <= ctl.ld_c || (r_vld_c && !ctl.ld_d);
            r_vld_d <= ctl.ld_d || (r_vld_d && !ctl.ld_e);
            r_vld_e <= ctl.ld_e || (r_vld_e && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ld_b) begin
            r_done_b <= !ctl.run_b;
        end
        if (ctl.ld_c) begin
            r_done_c <= r_done_b;
        end
        if (ctl.ld_d) begin
            r_done_d <= r_done_c;
        end
        if (ctl.ld_e) begin
            r_done_e <= r_done_d;
        end
    end

    assign o_out_valid = r_vld_e;
    assign o_move_done = r_done_e;

    a_done_zero_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_move_done |-> o_left_power == '0 && o_right_power == '0)
        else $error("finished move reported with nonzero power");

    a_empty_entry_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld_a |-> o_in_ready)
        else $error("empty input register refused a transfer");

    a_blocked_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld_d && !rdy_e |=> r_vld_d && $stable(r_done_d))
        else $error("blocked stage lost or changed its item");

    a_no_output_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !ctl.ld_e)
        else $error("output register overwritten while stalled");

endmodule
